### hw/rtl/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZW decoder package
// Shared constants, code classes and the queue item type.
// ----------------------------------------------------------------------------
package lzw_pkg;

   localparam int CODE_W            = 12;
   localparam int BYTE_W            = 8;
   localparam int WIDTH_W           = 4;
   localparam int STATUS_W          = 2;
   localparam int DICT_DEPTH        = 4096;
   localparam int CODE_BITS_MAX_DEF = 12;
   localparam int MAX_STRING_DEF    = 64;
   localparam int LITERAL_COUNT     = 256;
   localparam int FIRST_FREE        = 259;
   localparam int WIDTH_START       = 9;

   localparam logic [CODE_W-1:0] CODE_END   = 12'd256;
   localparam logic [CODE_W-1:0] CODE_WIDEN = 12'd257;
   localparam logic [CODE_W-1:0] CODE_CLEAR = 12'd258;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_END     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FORMAT  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TOOLONG = 2'd3;

   typedef enum logic [2:0] {
      KIND_LITERAL = 3'd0,
      KIND_END     = 3'd1,
      KIND_WIDEN   = 3'd2,
      KIND_CLEAR   = 3'd3,
      KIND_ENTRY   = 3'd4
   } kind_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      kind_type          kind;
   } item_type;

endpackage

### hw/rtl/lzw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/lzw_front.sv
// ----------------------------------------------------------------------------
// LZW decoder front end
// Accepts codes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lzw_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [lzw_pkg::CODE_W-1:0] req_code,
   output logic                      q_valid,
   output lzw_pkg::item_type         q_item,
   input  logic                      q_pop
);

   lzw_pkg::item_type slot_ff [2];
   lzw_pkg::item_type slot_in;
   logic [1:0]        count_ff, count_in;
   logic              push;

   always_comb begin
      slot_in.code = req_code;
      if (req_code < 12'(lzw_pkg::LITERAL_COUNT)) begin
         slot_in.kind = lzw_pkg::KIND_LITERAL;
      end else if (req_code == lzw_pkg::CODE_END) begin
         slot_in.kind = lzw_pkg::KIND_END;
      end else if (req_code == lzw_pkg::CODE_WIDEN) begin
         slot_in.kind = lzw_pkg::KIND_WIDEN;
      end else if (req_code == lzw_pkg::CODE_CLEAR) begin
         slot_in.kind = lzw_pkg::KIND_CLEAR;
      end else begin
         slot_in.kind = lzw_pkg::KIND_ENTRY;
      end
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[0];
   assign count_in  = count_ff + 2'(push) - 2'(q_pop && q_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_valid) begin
         if (push) begin
            slot_ff[0] <= slot_in;
         end else begin
            slot_ff[0] <= slot_ff[1];
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot_ff[0] <= slot_in;
         end else begin
            slot_ff[1] <= slot_in;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("front queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !q_pop) |=> count_ff == 2'd2)
      else $error("full queue lost an entry");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> !q_pop || !q_valid)
      else $error("pop from empty queue");

endmodule

### hw/rtl/lzw_back.sv
// ----------------------------------------------------------------------------
// LZW decoder back end
// Walks the dictionary chain, reverses the string and emits its bytes.
// ----------------------------------------------------------------------------
module lzw_back #(
   parameter int CODE_BITS_MAX = lzw_pkg::CODE_BITS_MAX_DEF,
   parameter int MAX_STRING    = lzw_pkg::MAX_STRING_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  lzw_pkg::item_type            q_item,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lzw_pkg::BYTE_W-1:0]   rsp_data_byte,
   output logic                         rsp_byte_valid,
   output logic                         rsp_last,
   output logic [lzw_pkg::STATUS_W-1:0] rsp_status,
   output logic [lzw_pkg::WIDTH_W-1:0]  rsp_code_width
);

   localparam int CW = lzw_pkg::CODE_W;
   localparam int BW = lzw_pkg::BYTE_W;
   localparam int DW = CW + BW;
   localparam int SW = $clog2(MAX_STRING);
   localparam int NW = $clog2(MAX_STRING + 1);
   localparam logic [CW-1:0] DICT_LIMIT =
      CW'((CODE_BITS_MAX >= 12) ? 4095 : (1 << CODE_BITS_MAX));
   localparam logic [NW-1:0] MAX_N     = NW'(MAX_STRING);
   localparam logic [4:0]    WIDTH_MAX = 5'(CODE_BITS_MAX);
   localparam logic [4:0]    WIDTH_RST = 5'(lzw_pkg::WIDTH_START);
   localparam logic [CW-1:0] FREE_RST  = CW'(lzw_pkg::FIRST_FREE);
   localparam logic [CW-1:0] LIT_TOP   = CW'(lzw_pkg::LITERAL_COUNT);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_WALK = 6'b000010,
      ST_WAIT = 6'b000100,
      ST_POP  = 6'b001000,
      ST_SHOW = 6'b010000,
      ST_KW   = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   prev_ff, prev_in, free_ff, free_in, cur_ff, cur_in, code_ff, code_in;
   logic [4:0]      width_ff, width_in;
   logic            expect_ff, expect_in, kw_ff, kw_in;
   logic [NW-1:0]   n_ff, n_in, i_ff, i_in;
   logic [BW-1:0]   first_ff, first_in;
   logic            ov_ff, ov_in, obv_ff, obv_in, olast_ff, olast_in;
   logic [BW-1:0]   obyte_ff, obyte_in;
   logic [1:0]      ost_ff, ost_in;

   logic            dict_we, stk_we;
   logic [CW-1:0]   dict_rd_addr;
   logic [DW-1:0]   dict_rd_data;
   logic [SW-1:0]   stk_wr_addr, stk_rd_addr;
   logic [BW-1:0]   stk_wr_data, stk_rd_data;
   logic            out_free, kw_now;

   lzw_ram #(.WIDTH(DW), .DEPTH(lzw_pkg::DICT_DEPTH)) u_dict (
      .clock   (clock),
      .wr_en   (dict_we),
      .wr_addr (free_ff),
      .wr_data ({prev_ff, cur_ff[BW-1:0]}),
      .rd_addr (dict_rd_addr),
      .rd_data (dict_rd_data)
   );

   lzw_ram #(.WIDTH(BW), .DEPTH(MAX_STRING)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign out_free     = !ov_ff;
   assign kw_now       = (q_item.code == free_ff) && (free_ff < DICT_LIMIT);
   assign dict_rd_addr = cur_ff;
   assign stk_wr_addr  = n_ff[SW-1:0];
   assign stk_rd_addr  = SW'(i_ff - NW'(1));

   always_comb begin
      state_in  = state_ff;
      prev_in   = prev_ff;
      free_in   = free_ff;
      width_in  = width_ff;
      expect_in = expect_ff;
      cur_in    = cur_ff;
      code_in   = code_ff;
      kw_in     = kw_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      first_in  = first_ff;
      ov_in     = ov_ff && !rsp_ready;
      obv_in    = obv_ff;
      olast_in  = olast_ff;
      obyte_in  = obyte_ff;
      ost_in    = ost_ff;
      q_pop     = 1'b0;
      dict_we   = 1'b0;
      stk_we    = 1'b0;
      stk_wr_data = cur_ff[BW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop    = 1'b1;
               ov_in    = 1'b1;
               obv_in   = 1'b0;
               olast_in = 1'b1;
               obyte_in = '0;
               ost_in   = lzw_pkg::STATUS_OK;
               if (expect_ff) begin
                  if (q_item.kind == lzw_pkg::KIND_LITERAL) begin
                     expect_in = 1'b0;
                     prev_in   = q_item.code;
                     obv_in    = 1'b1;
                     obyte_in  = q_item.code[BW-1:0];
                  end else begin
                     ost_in = lzw_pkg::STATUS_FORMAT;
                  end
               end else begin
                  case (q_item.kind)
                     lzw_pkg::KIND_END, lzw_pkg::KIND_CLEAR: begin
                        free_in   = FREE_RST;
                        width_in  = WIDTH_RST;
                        expect_in = 1'b1;
                        if (q_item.kind == lzw_pkg::KIND_END) begin
                           ost_in = lzw_pkg::STATUS_END;
                        end
                     end
                     lzw_pkg::KIND_WIDEN: begin
                        if (width_ff < WIDTH_MAX) begin
                           width_in = width_ff + 5'd1;
                        end
                     end
                     default: begin
                        if (q_item.code > free_ff || (q_item.code == free_ff && !kw_now)) begin
                           ost_in = lzw_pkg::STATUS_FORMAT;
                        end else begin
                           ov_in    = 1'b0;
                           kw_in    = kw_now;
                           code_in  = q_item.code;
                           cur_in   = kw_now ? prev_ff : q_item.code;
                           n_in     = '0;
                           state_in = ST_WALK;
                        end
                     end
                  endcase
               end
            end
         end
         ST_WALK: begin
            if (cur_ff >= LIT_TOP) begin
               if (n_ff >= MAX_N) begin
                  ov_in    = 1'b1;
                  obv_in   = 1'b0;
                  olast_in = 1'b1;
                  obyte_in = '0;
                  ost_in   = lzw_pkg::STATUS_TOOLONG;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WAIT;
               end
            end else if (n_ff >= MAX_N || (kw_ff && (n_ff + NW'(1)) >= MAX_N)) begin
               ov_in    = 1'b1;
               obv_in   = 1'b0;
               olast_in = 1'b1;
               obyte_in = '0;
               ost_in   = lzw_pkg::STATUS_TOOLONG;
               state_in = ST_IDLE;
            end else begin
               stk_we   = 1'b1;
               n_in     = n_ff + NW'(1);
               i_in     = n_ff + NW'(1);
               first_in = cur_ff[BW-1:0];
               if (free_ff < DICT_LIMIT) begin
                  dict_we = 1'b1;
                  free_in = free_ff + CW'(1);
               end
               prev_in  = code_ff;
               state_in = ST_POP;
            end
         end
         ST_WAIT: begin
            stk_we      = 1'b1;
            stk_wr_data = dict_rd_data[BW-1:0];
            n_in        = n_ff + NW'(1);
            cur_in      = dict_rd_data[DW-1:BW];
            state_in    = ST_WALK;
         end
         ST_POP: begin
            if (out_free) begin
               i_in     = i_ff - NW'(1);
               state_in = ST_SHOW;
            end
         end
         ST_SHOW: begin
            ov_in    = 1'b1;
            obv_in   = 1'b1;
            obyte_in = stk_rd_data;
            olast_in = (i_ff == '0) && !kw_ff;
            ost_in   = lzw_pkg::STATUS_OK;
            if (i_ff != '0) begin
               state_in = ST_POP;
            end else if (kw_ff) begin
               state_in = ST_KW;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_KW: begin
            if (out_free) begin
               ov_in    = 1'b1;
               obv_in   = 1'b1;
               obyte_in = first_ff;
               olast_in = 1'b1;
               ost_in   = lzw_pkg::STATUS_OK;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         prev_ff   <= '0;
         free_ff   <= FREE_RST;
         width_ff  <= WIDTH_RST;
         expect_ff <= 1'b1;
         ov_ff     <= 1'b0;
         n_ff      <= '0;
         i_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         prev_ff   <= prev_in;
         free_ff   <= free_in;
         width_ff  <= width_in;
         expect_ff <= expect_in;
         ov_ff     <= ov_in;
         n_ff      <= n_in;
         i_ff      <= i_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      code_ff  <= code_in;
      kw_ff    <= kw_in;
      first_ff <= first_in;
      obv_ff   <= obv_in;
      olast_ff <= olast_in;
      obyte_ff <= obyte_in;
      ost_ff   <= ost_in;
   end

   assign rsp_valid      = ov_ff;
   assign rsp_data_byte  = obyte_ff;
   assign rsp_byte_valid = obv_ff;
   assign rsp_last       = olast_ff;
   assign rsp_status     = ost_ff;
   assign rsp_code_width = width_ff[lzw_pkg::WIDTH_W-1:0];

   assert property (@(posedge clock) disable iff (reset) n_ff <= MAX_N)
      else $error("string stack overflow");
   assert property (@(posedge clock) disable iff (reset) i_ff <= n_ff)
      else $error("pop index beyond stack fill");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHOW) |-> !ov_ff)
      else $error("result register overwritten");
   assert property (@(posedge clock) disable iff (reset) free_ff <= DICT_LIMIT)
      else $error("next free entry beyond dictionary limit");

endmodule

### hw/rtl/lzw_code_decoder.sv
// ----------------------------------------------------------------------------
// LZW code decoder
// Decodes one LZW code per transaction into a sequence of byte results.
// ----------------------------------------------------------------------------
// Each code yields one result per decoded byte (or one status result). A
// dictionary code first leaves the queue, then its chain is walked link by
// link through the dictionary RAM's single registered read port, and then
// the reversed string is read back from the stack RAM, where a byte is read
// only after the previous result has been taken.
// A two-entry code queue lets new codes arrive while a string is still
// being emitted. The dictionary needs no clearing pass after reset.
module lzw_code_decoder #(
   parameter int CODE_BITS_MAX = lzw_pkg::CODE_BITS_MAX_DEF,
   parameter int MAX_STRING    = lzw_pkg::MAX_STRING_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lzw_pkg::CODE_W-1:0]   req_code,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lzw_pkg::BYTE_W-1:0]   rsp_data_byte,
   output logic                         rsp_byte_valid,
   output logic                         rsp_last,
   output logic [lzw_pkg::STATUS_W-1:0] rsp_status,
   output logic [lzw_pkg::WIDTH_W-1:0]  rsp_code_width
);

   logic              q_valid, q_pop;
   lzw_pkg::item_type q_item;

   lzw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_code  (req_code),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   lzw_back #(.CODE_BITS_MAX(CODE_BITS_MAX), .MAX_STRING(MAX_STRING)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .rsp_code_width (rsp_code_width)
   );

endmodule
